[src/msr_pkg.sv]
package msr_pkg;

  localparam int SPEED_W       = 9;
  localparam int STEP_W        = 10;
  localparam int DUR_W         = 16;
  localparam int NOW_W         = 32;
  localparam int MUL_B_W       = 9;
  localparam int PROD_W        = STEP_W + MUL_B_W;
  localparam int PWM_W         = 8;
  localparam int TIME_BITS_DEF = 32;

  localparam logic [DUR_W-1:0] STOP_DURATION = 16'd10;
  localparam logic [DUR_W-1:0] ACC_DUR_RST   = 16'd500;

  // Configuration register indexes
  localparam logic CFG_MODE    = 1'b0;
  localparam logic CFG_ACC_DUR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_CHECK,
    ST_MUL,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ser_sts_t;

  function automatic logic [STEP_W-1:0] abs_step(input logic [STEP_W-1:0] v);
    return v[STEP_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

[src/msr_div.sv]
module msr_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [msr_pkg::STEP_W-1:0]       dividend,
  input  logic [msr_pkg::DUR_W-1:0]        divisor,
  output logic [msr_pkg::STEP_W-1:0]       quotient,
  output msr_pkg::ser_sts_t                sts
);

  localparam int N_W   = msr_pkg::STEP_W;
  localparam int D_W   = msr_pkg::DUR_W;
  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [N_W-1:0]   dd_r, q_r;
  logic [D_W-1:0]   rem_r, dvs_r;
  logic [D_W:0]     sh, sub;
  logic             ge;
  logic [D_W-1:0]   rem_nxt;

  // One quotient bit per cycle, restoring form
  always_comb begin
    sh      = {rem_r, dd_r[N_W-1]};
    sub     = sh - {1'b0, dvs_r};
    ge      = (sh >= {1'b0, dvs_r});
    rem_nxt = ge ? sub[D_W-1:0] : sh[D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dd_r  <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      dd_r  <= {dd_r[N_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[N_W-2:0], ge};
    end
  end

  assign quotient = q_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

[src/msr_mul.sv]
module msr_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [msr_pkg::STEP_W-1:0]       mcand,
  input  logic [msr_pkg::MUL_B_W-1:0]      mplier,
  output logic [msr_pkg::PROD_W-1:0]       product,
  output msr_pkg::ser_sts_t                sts
);

  localparam int B_W   = msr_pkg::MUL_B_W;
  localparam int P_W   = msr_pkg::PROD_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [P_W-1:0]   acc_r, mc_r;
  logic [B_W-1:0]   mp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(B_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift-add, multiplier bit zero first
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      mc_r  <= P_W'(mcand);
      mp_r  <= mplier;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
      mc_r <= {mc_r[P_W-2:0], 1'b0};
      mp_r <= {1'b0, mp_r[B_W-1:1]};
    end
  end

  assign product  = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

[src/motor_speed_ramp.sv]
// Channel | Dir | Handshake            | Payload, lowest bit up
// in_     | in  | in_tvalid/in_tready   | tdata: target_speed[8:0], now_ms[40:9]
// out_    | out | out_tvalid/out_tready | tdata: pwm_forward, pwm_backward, speed_now;
//         |     |                       | tuser: updated
// cfg_    | in  | cfg_valid/cfg_ready   | cfg_addr: register index, cfg_data: value
//
// One item at a time. An item that leaves the speed alone goes from evaluation straight
// to the write step. A new target runs the 10-bit serial divider and, short of
// saturation, the 9-bit serial multiplier; a repeated target skips the divider.
// Reset is synchronous on rst_n: ramp state to zero, mode to stop, acc_duration to 500.
// A stalled output holds its result; the next item finishes and waits in the write step.
module motor_speed_ramp #(
  parameter int TIME_BITS = msr_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // target_speed[8:0], now_ms[40:9], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pwm_forward[7:0], pwm_backward[15:8], speed_now[24:16]
  output logic        out_tuser,  // updated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam int SW = msr_pkg::SPEED_W;
  localparam int TW = msr_pkg::STEP_W;
  localparam int DW = msr_pkg::DUR_W;
  localparam int PW = msr_pkg::PWM_W;

  msr_pkg::state_t state_r, state_nxt;

  // Configuration
  logic          mode_r;
  logic [DW-1:0] acc_r;

  // Ramp state
  logic signed [SW-1:0] cur_r, last_tgt_r;
  logic signed [TW-1:0] step_r;
  logic [TIME_BITS-1:0] last_time_r;

  // Item under work
  logic signed [SW-1:0] tgt_r;
  logic [TIME_BITS-1:0] now_r, dt_r;
  logic [DW-1:0]        dur_r;
  logic signed [TW-1:0] diff_r;
  logic                 upd_r;

  // Output register
  logic          out_tvalid_r;
  logic [PW-1:0] out_fwd_r, out_bwd_r;
  logic [SW-1:0] out_speed_r;
  logic          out_upd_r;

  logic                 div_start, mul_start, out_load;
  msr_pkg::ser_sts_t    div_sts, mul_sts;
  logic [TW-1:0]        div_q;
  logic [msr_pkg::PROD_W-1:0] mul_p;

  logic signed [SW-1:0] raw_tgt, tgt_sel;
  logic [DW-1:0]        dur_sel;
  logic signed [TW-1:0] diff_c, step_c, cur_ext, cur_mv;
  logic [TW-1:0]        diff_abs, rem_c, mag_c;
  logic                 sat_hit;
  logic [SW-1:0]        neg_cur;

  // Pick the target and duration from mode; clamp -256 to -255, zero duration to 1
  always_comb begin
    raw_tgt = in_tdata[SW-1:0];
    if (!mode_r) begin
      tgt_sel = '0;
      dur_sel = msr_pkg::STOP_DURATION;
    end else begin
      tgt_sel = (raw_tgt == {1'b1, {(SW-1){1'b0}}}) ? {1'b1, {(SW-2){1'b0}}, 1'b1} : raw_tgt;
      dur_sel = (acc_r == '0) ? DW'(1) : acc_r;
    end
  end

  always_comb begin
    diff_c   = {tgt_r[SW-1], tgt_r} - {cur_r[SW-1], cur_r};
    diff_abs = msr_pkg::abs_step(diff_c);
    rem_c    = msr_pkg::abs_step(diff_r);
    mag_c    = msr_pkg::abs_step(step_r);
    // Truncated quotient with the sign of the difference, never zero
    if (div_q == '0) begin
      step_c = diff_r[TW-1] ? {TW{1'b1}} : TW'(1);
    end else begin
      step_c = diff_r[TW-1] ? (~div_q + 1'b1) : div_q;
    end
    sat_hit = (mag_c != '0) && (dt_r >= TIME_BITS'(rem_c));
    cur_ext = {cur_r[SW-1], cur_r};
    cur_mv  = step_r[TW-1] ? (cur_ext - mul_p[TW-1:0]) : (cur_ext + mul_p[TW-1:0]);
    neg_cur = ~cur_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      msr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = msr_pkg::ST_EVAL;
      end
      msr_pkg::ST_EVAL: begin
        if (tgt_r == cur_r) begin
          state_nxt = msr_pkg::ST_WRITE;
        end else if (tgt_r != last_tgt_r) begin
          div_start = 1'b1;
          state_nxt = msr_pkg::ST_DIV;
        end else begin
          state_nxt = msr_pkg::ST_CHECK;
        end
      end
      msr_pkg::ST_DIV: begin
        if (div_sts.done) state_nxt = msr_pkg::ST_CHECK;
      end
      msr_pkg::ST_CHECK: begin
        if (dt_r == '0 || sat_hit) begin
          state_nxt = msr_pkg::ST_WRITE;
        end else begin
          mul_start = 1'b1;
          state_nxt = msr_pkg::ST_MUL;
        end
      end
      msr_pkg::ST_MUL: begin
        if (mul_sts.done) state_nxt = msr_pkg::ST_WRITE;
      end
      msr_pkg::ST_WRITE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = msr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msr_pkg::ST_IDLE;
    endcase
  end

  // Configuration, output valid and ramp state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      acc_r        <= msr_pkg::ACC_DUR_RST;
      cur_r        <= '0;
      last_tgt_r   <= '0;
      step_r       <= '0;
      last_time_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_addr)
          msr_pkg::CFG_MODE:    mode_r <= cfg_data[0];
          msr_pkg::CFG_ACC_DUR: acc_r  <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        msr_pkg::ST_EVAL: begin
          if (tgt_r != cur_r) last_time_r <= now_r;
        end
        msr_pkg::ST_DIV: begin
          if (div_sts.done) begin
            step_r     <= step_c;
            last_tgt_r <= tgt_r;
          end
        end
        msr_pkg::ST_CHECK: begin
          // Elapsed time covers the gap: land on the target without multiplying
          if (dt_r != '0 && sat_hit) cur_r <= tgt_r;
        end
        msr_pkg::ST_MUL: begin
          if (mul_sts.done) begin
            cur_r <= (mul_p < msr_pkg::PROD_W'(rem_c)) ? cur_mv[SW-1:0] : tgt_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Item payload and output data, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      msr_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          tgt_r <= tgt_sel;
          now_r <= TIME_BITS'(in_tdata[SW +: msr_pkg::NOW_W]);
          dur_r <= dur_sel;
        end
      end
      msr_pkg::ST_EVAL: begin
        upd_r  <= 1'b0;
        diff_r <= diff_c;
        // Repeated target: modular elapsed time; new target: one step
        dt_r   <= (last_tgt_r == tgt_r) ? (now_r - last_time_r) : TIME_BITS'(1);
      end
      msr_pkg::ST_CHECK: begin
        if (dt_r != '0) upd_r <= 1'b1;
      end
      default: ;
    endcase
    if (out_load) begin
      out_fwd_r   <= cur_r[SW-1] ? '0 : cur_r[PW-1:0];
      out_bwd_r   <= cur_r[SW-1] ? neg_cur[PW-1:0] : '0;
      out_speed_r <= cur_r;
      out_upd_r   <= upd_r;
    end
  end

  msr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff_abs),
    .divisor  (dur_r),
    .quotient (div_q),
    .sts      (div_sts)
  );

  msr_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mag_c),
    .mplier  (dt_r[msr_pkg::MUL_B_W-1:0]),
    .product (mul_p),
    .sts     (mul_sts)
  );

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_speed_r, out_bwd_r, out_fwd_r};
  assign out_tuser  = out_upd_r;

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == msr_pkg::ST_EVAL)
    else $error("accepted item did not move to evaluation");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == msr_pkg::ST_DIV)
    else $error("divider finished outside the divide step");

  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_sts.done |-> state_r == msr_pkg::ST_MUL)
    else $error("multiplier finished outside the multiply step");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_start && div_sts.busy) && !(mul_start && mul_sts.busy))
    else $error("serial unit started while busy");

  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r != {1'b1, {(SW-1){1'b0}}})
    else $error("current speed reached -256");

endmodule
